// ----- design/twc_pkg.sv -----
package twc_pkg;

  localparam int ALPHABET_SIZE = 52;
  localparam int LETTER_BITS   = 6;
  localparam int OUT_COUNT_W   = 20;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_FULL     = 2'd2,
    ERR_SPARE    = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_NEW,
    ST_CNT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   valid;
    logic [LETTER_BITS-1:0] code;
  } letter_t;

  function automatic letter_t letter_code(input logic [7:0] b);
    letter_t    res;
    logic [7:0] diff;
    res  = '0;
    diff = '0;
    if (b inside {[8'h41:8'h5A]}) begin
      diff      = b - 8'h41;
      res.valid = 1'b1;
    end else if (b inside {[8'h61:8'h7A]}) begin
      diff      = b - 8'h61 + 8'd26;
      res.valid = 1'b1;
    end
    res.code = diff[LETTER_BITS-1:0];
    return res;
  endfunction

endpackage

// ----- design/trie_word_count_dictionary_core.sv -----
// Word-frequency trie, fed one letter per transfer. A-Z and a-z are letter codes 0..51; tlast
// marks a word's final letter and tuser selects insert, lookup, clear or none (ignored). Each
// node owns one row of 52 child indices in a single-port-read memory, so a letter that walks
// the trie costs a row read and a decision, plus a further step when an insert allocates a node
// (the new node's row is zeroed and its count set to zero, or to one on a word's final letter).
// Letters after a bad character, a full table or a lookup miss are skipped without a row read.
// A found final letter adds a count read and the result handoff, and a word end also waits on
// any stall on the result side. A clear, like reset, passes through ST_INIT, which zeroes the
// root row before the block takes its next transfer.
module trie_word_count_dictionary_core
  import twc_pkg::*;
#(
  parameter int NODE_COUNT = 4096,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        in_tlast,   // word_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [19:0] word_count, [23:20] zero
  output logic [1:0]  out_tuser   // [1:0] error_code
);

  localparam int NB     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int ROW_W  = ALPHABET_SIZE * NB;
  localparam logic [NB:0] NODE_LIMIT = (NB+1)'(NODE_COUNT);

  typedef logic [ALPHABET_SIZE-1:0][NB-1:0] row_t;

  state_t                 state_r, state_nxt;
  logic [NB-1:0]          cursor_r, cursor_nxt;
  logic                   missed_r, missed_nxt;
  err_t                   err_r, err_nxt;
  logic [NB:0]            next_free_r, next_free_nxt;
  logic [LETTER_BITS-1:0] id_r, id_nxt;
  logic                   insert_r, insert_nxt;
  logic                   last_r, last_nxt;
  logic [COUNT_BITS-1:0]  pend_cnt_r, pend_cnt_nxt;
  err_t                   pend_err_r, pend_err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  err_t                   out_err_r, out_err_nxt;

  logic                   row_we, row_re;
  logic [NB-1:0]          row_waddr, row_raddr;
  row_t                   row_wdata, row_q;
  logic                   cnt_we, cnt_re;
  logic [NB-1:0]          cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0]  cnt_wdata, cnt_q;

  kind_t                  in_kind;
  letter_t                letter;
  logic                   in_xfer, active, out_free;
  logic [NB-1:0]          child;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [OUT_COUNT_W+COUNT_BITS-1:0] pend_wide;

  twc_row_ram #(.DEPTH(NODE_COUNT), .WIDTH(ROW_W)) u_child_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_q)
  );

  twc_row_ram #(.DEPTH(NODE_COUNT), .WIDTH(COUNT_BITS)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  assign in_kind   = kind_t'(in_tuser);
  assign letter    = letter_code(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign active    = (err_r == ERR_NONE) && !missed_r;
  assign out_free  = !out_valid_r || out_tready;
  assign child     = row_q[id_r];
  assign cnt_inc   = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign pend_wide = {{OUT_COUNT_W{1'b0}}, pend_cnt_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24-OUT_COUNT_W){1'b0}}, out_cnt_r};
  assign out_tuser  = out_err_r;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    missed_nxt    = missed_r;
    err_nxt       = err_r;
    next_free_nxt = next_free_r;
    id_nxt        = id_r;
    insert_nxt    = insert_r;
    last_nxt      = last_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_err_nxt  = pend_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_cnt_nxt   = out_cnt_r;
    out_err_nxt   = out_err_r;
    row_we        = 1'b0;
    row_waddr     = cursor_r;
    row_wdata     = row_q;
    row_re        = 1'b0;
    row_raddr     = cursor_r;
    cnt_we        = 1'b0;
    cnt_waddr     = cursor_r;
    cnt_wdata     = cnt_inc;
    cnt_re        = 1'b0;
    cnt_raddr     = child;

    case (state_r)
      ST_INIT: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = '0;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_kind)
            KIND_CLEAR: begin
              next_free_nxt = (NB+1)'(1);
              cursor_nxt    = '0;
              missed_nxt    = 1'b0;
              err_nxt       = ERR_NONE;
              state_nxt     = ST_INIT;
            end
            KIND_INSERT, KIND_LOOKUP: begin
              id_nxt     = letter.code;
              insert_nxt = (in_kind == KIND_INSERT);
              last_nxt   = in_tlast;
              if (active && letter.valid) begin
                row_re    = 1'b1;
                state_nxt = ST_LOOK;
              end else begin
                if (active) begin
                  err_nxt = ERR_BAD_CHAR;
                end
                if (in_tlast) begin
                  pend_cnt_nxt = '0;
                  pend_err_nxt = active ? ERR_BAD_CHAR : err_r;
                  cursor_nxt   = '0;
                  missed_nxt   = 1'b0;
                  err_nxt      = ERR_NONE;
                  state_nxt    = ST_OUT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
        if (child != '0) begin
          cursor_nxt = child;
          if (last_r) begin
            cnt_re    = 1'b1;
            state_nxt = ST_CNT;
          end
        end else if (!insert_r) begin
          missed_nxt = 1'b1;
          if (last_r) begin
            pend_cnt_nxt = '0;
            pend_err_nxt = ERR_NONE;
            cursor_nxt   = '0;
            missed_nxt   = 1'b0;
            state_nxt    = ST_OUT;
          end
        end else if (next_free_r >= NODE_LIMIT) begin
          err_nxt = ERR_FULL;
          if (last_r) begin
            pend_cnt_nxt = '0;
            pend_err_nxt = ERR_FULL;
            cursor_nxt   = '0;
            err_nxt      = ERR_NONE;
            state_nxt    = ST_OUT;
          end
        end else begin
          row_we            = 1'b1;
          row_waddr         = cursor_r;
          row_wdata         = row_q;
          row_wdata[id_r]   = next_free_r[NB-1:0];
          cursor_nxt        = next_free_r[NB-1:0];
          next_free_nxt     = next_free_r + 1'b1;
          state_nxt         = ST_NEW;
        end
      end
      ST_NEW: begin
        row_we    = 1'b1;
        row_waddr = cursor_r;
        row_wdata = '0;
        cnt_we    = 1'b1;
        cnt_waddr = cursor_r;
        cnt_wdata = last_r ? COUNT_BITS'(1) : '0;
        state_nxt = ST_IDLE;
        if (last_r) begin
          pend_cnt_nxt = COUNT_BITS'(1);
          pend_err_nxt = ERR_NONE;
          cursor_nxt   = '0;
          state_nxt    = ST_OUT;
        end
      end
      ST_CNT: begin
        cnt_we       = insert_r;
        cnt_waddr    = cursor_r;
        cnt_wdata    = cnt_inc;
        pend_cnt_nxt = insert_r ? cnt_inc : cnt_q;
        pend_err_nxt = ERR_NONE;
        cursor_nxt   = '0;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = pend_wide[OUT_COUNT_W-1:0];
          out_err_nxt   = pend_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cursor_r    <= '0;
      missed_r    <= 1'b0;
      err_r       <= ERR_NONE;
      next_free_r <= (NB+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      missed_r    <= missed_nxt;
      err_r       <= err_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    insert_r   <= insert_nxt;
    last_r     <= last_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    pend_err_r <= pend_err_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_err_r  <= out_err_nxt;
  end

endmodule

// ----- design/twc_row_ram.sv -----
module twc_row_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/trie_word_count_dictionary_core_tb.sv -----
`timescale 1ns / 1ps

module trie_word_count_dictionary_core_tb;
  import twc_pkg::*;

  localparam int NODES     = 4096;
  localparam int CNT_BITS  = 20;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef logic [7:0] byteq_t [$];
  typedef kind_t kindq_t [$];

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] cnt;
    err_t                   err;
  } word_res_t;

  typedef struct {
    kind_t                  kind;
    logic [7:0]             chr;
    bit                     last;
    bit                     typed;
    logic [OUT_COUNT_W-1:0] cnt;
    err_t                   err;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  // trie mirror
  logic [11:0]         trie_child [int];
  logic [CNT_BITS-1:0] trie_count [NODES];
  int                  trie_next;
  logic [11:0]         walk_node;
  bit                  walk_missed;
  err_t                walk_err;

  word_res_t expected_words [$];
  byteq_t    vocab [24];
  bit        in_burst = 1'b0;
  bit        out_burst = 1'b0;
  int        fails = 0;
  int        n_items = 0;
  int        n_checked = 0;
  int        n_hits = 0;
  int        n_miss = 0;
  int        n_bad = 0;
  int        n_full = 0;
  int        n_clears = 0;

  stim_row_t dir_rows [24] = '{
    '{KIND_INSERT, "A",   1'b1, 1'b1, 20'd1, ERR_NONE},
    '{KIND_INSERT, "A",   1'b1, 1'b1, 20'd2, ERR_NONE},
    '{KIND_LOOKUP, "A",   1'b1, 1'b1, 20'd2, ERR_NONE},
    '{KIND_LOOKUP, "z",   1'b1, 1'b1, 20'd0, ERR_NONE},
    '{KIND_INSERT, "Z",   1'b0, 1'b0, 20'd0, ERR_NONE},
    '{KIND_INSERT, "a",   1'b1, 1'b1, 20'd1, ERR_NONE},
    '{KIND_LOOKUP, "Z",   1'b0, 1'b0, 20'd0, ERR_NONE},
    '{KIND_LOOKUP, "a",   1'b1, 1'b1, 20'd1, ERR_NONE},
    '{KIND_INSERT, 8'h40, 1'b0, 1'b0, 20'd0, ERR_NONE},
    '{KIND_INSERT, "b",   1'b1, 1'b1, 20'd0, ERR_BAD_CHAR},
    '{KIND_LOOKUP, 8'h5B, 1'b1, 1'b1, 20'd0, ERR_BAD_CHAR},
    '{KIND_INSERT, 8'h60, 1'b1, 1'b1, 20'd0, ERR_BAD_CHAR},
    '{KIND_INSERT, 8'h7B, 1'b1, 1'b1, 20'd0, ERR_BAD_CHAR},
    '{KIND_LOOKUP, 8'h00, 1'b1, 1'b1, 20'd0, ERR_BAD_CHAR},
    '{KIND_INSERT, 8'hFF, 1'b1, 1'b1, 20'd0, ERR_BAD_CHAR},
    '{KIND_LOOKUP, "A",   1'b0, 1'b0, 20'd0, ERR_NONE},
    '{KIND_INSERT, "B",   1'b1, 1'b0, 20'd0, ERR_NONE},
    '{KIND_LOOKUP, "q",   1'b0, 1'b0, 20'd0, ERR_NONE},
    '{KIND_INSERT, "r",   1'b1, 1'b1, 20'd0, ERR_NONE},
    '{KIND_NONE,   8'hFF, 1'b1, 1'b0, 20'd0, ERR_NONE},
    '{KIND_LOOKUP, "A",   1'b1, 1'b1, 20'd2, ERR_NONE},
    '{KIND_CLEAR,  8'hAA, 1'b1, 1'b0, 20'd0, ERR_NONE},
    '{KIND_LOOKUP, "A",   1'b1, 1'b1, 20'd0, ERR_NONE},
    '{KIND_INSERT, "z",   1'b1, 1'b1, 20'd1, ERR_NONE}
  };

  trie_word_count_dictionary_core #(
    .NODE_COUNT(NODES),
    .COUNT_BITS(CNT_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int letter_index(input logic [7:0] b);
    if (b >= "A" && b <= "Z") return int'(b - "A");
    if (b >= "a" && b <= "z") return int'(b - "a") + 26;
    return -1;
  endfunction

  function automatic logic [7:0] letter_byte(input int c);
    return (c < 26) ? 8'("A" + c) : 8'("a" + c - 26);
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (letter_index(b) >= 0);
    return b;
  endfunction

  function automatic void trie_clear();
    trie_child.delete();
    foreach (trie_count[i]) trie_count[i] = '0;
    trie_next   = 1;
    walk_node   = '0;
    walk_missed = 1'b0;
    walk_err    = ERR_NONE;
  endfunction

  function automatic void trie_apply(input kind_t k, input logic [7:0] b, input bit last,
                                     output bit has_res, output word_res_t res);
    int          code;
    int          slot;
    logic [11:0] child;
    has_res = 1'b0;
    res     = '{cnt: '0, err: ERR_NONE};
    if (k == KIND_CLEAR) begin
      trie_clear();
      n_clears++;
      return;
    end
    if (k == KIND_NONE) return;
    if (walk_err == ERR_NONE && !walk_missed) begin
      code = letter_index(b);
      if (code < 0) begin
        walk_err = ERR_BAD_CHAR;
      end else begin
        slot  = int'(walk_node) * ALPHABET_SIZE + code;
        child = trie_child.exists(slot) ? trie_child[slot] : 12'd0;
        if (child == 0) begin
          if (k == KIND_LOOKUP) begin
            walk_missed = 1'b1;
          end else if (trie_next >= NODES) begin
            walk_err = ERR_FULL;
          end else begin
            child = 12'(trie_next);
            trie_next++;
            trie_child[slot] = child;
          end
        end
        if (child != 0) walk_node = child;
      end
    end
    if (!last) return;
    has_res = 1'b1;
    if (walk_err == ERR_NONE && !walk_missed) begin
      if (k == KIND_INSERT && trie_count[walk_node] < CNT_MAX)
        trie_count[walk_node]++;
      res.cnt = trie_count[walk_node][OUT_COUNT_W-1:0];
      n_hits++;
    end else if (walk_err == ERR_BAD_CHAR) begin
      n_bad++;
    end else if (walk_err == ERR_FULL) begin
      n_full++;
    end else begin
      n_miss++;
    end
    res.err     = walk_err;
    walk_node   = '0;
    walk_missed = 1'b0;
    walk_err    = ERR_NONE;
  endfunction

  task automatic send_item(input kind_t k, input logic [7:0] b, input bit last, input bit typed,
                           input logic [OUT_COUNT_W-1:0] t_cnt, input err_t t_err);
    int        gap;
    bit        has_res;
    word_res_t res;
    gap = in_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    n_items++;
    trie_apply(k, b, last, has_res, res);
    if (has_res) begin
      if (typed) begin
        res.cnt = t_cnt;
        res.err = t_err;
      end
      expected_words.push_back(res);
    end
    if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
  endtask

  task automatic send_word(input byteq_t chars, input kindq_t kinds);
    foreach (chars[i])
      send_item(kinds[i], chars[i], i == chars.size() - 1, 1'b0, '0, ERR_NONE);
  endtask

  task automatic send_random_word(input bit allow_clear);
    int     r;
    int     len;
    kind_t  k;
    byteq_t chars;
    kindq_t kinds;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_item(KIND_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0,
                ERR_NONE);
      return;
    end
    if (r == 3) begin
      if (allow_clear)
        send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0,
                  ERR_NONE);
      return;
    end
    if (r < 7) begin
      k = $urandom_range(0, 1) ? KIND_LOOKUP : KIND_INSERT;
      send_item(k, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0, ERR_NONE);
      return;
    end
    if (r < 85) begin
      chars = vocab[$urandom_range(0, 23)];
    end else begin
      len = $urandom_range(1, 10);
      repeat (len) chars.push_back(letter_byte($urandom_range(0, 51)));
    end
    k = ($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_LOOKUP;
    foreach (chars[i])
      kinds.push_back(($urandom_range(0, 9) == 0) ? kind_t'($urandom_range(0, 1)) : k);
    if ($urandom_range(0, 9) == 0)
      chars[$urandom_range(0, chars.size() - 1)] = junk_byte();
    send_word(chars, kinds);
  endtask

  initial begin
    int len;
    trie_clear();
    n_clears = 0;
    for (int i = 0; i < 12; i++) begin
      len = $urandom_range(1, 8);
      repeat (len) vocab[i].push_back(letter_byte($urandom_range(0, 51)));
    end
    for (int i = 12; i < 24; i++) begin
      vocab[i] = vocab[i - 12];
      len = $urandom_range(1, 3);
      repeat (len) vocab[i].push_back(letter_byte($urandom_range(0, 51)));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].chr, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].cnt, dir_rows[i].err);

    repeat (165) send_random_word(1'b1);
    send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0, ERR_NONE);
    repeat (165) send_random_word(1'b1);
    in_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d input transfers, %0d results checked: %0d counted or found, %0d lookup misses",
             n_items, n_checked, n_hits, n_miss);
    $display("%0d bad-character words, %0d table-full words, %0d dictionary clears",
             n_bad, n_full, n_clears);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int        stall;
    word_res_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      n_checked++;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected result: expected none, actual count %0d error %0d",
                 $time, out_tdata[19:0], out_tuser);
        fails++;
      end else begin
        want = expected_words.pop_front();
        if (out_tdata[19:0] !== want.cnt) begin
          $display("%0t word_count mismatch: expected %0d, actual %0d",
                   $time, want.cnt, out_tdata[19:0]);
          fails++;
        end
        if (out_tdata[23:20] !== 4'h0) begin
          $display("%0t tdata padding mismatch: expected 0, actual %0h", $time, out_tdata[23:20]);
          fails++;
        end
        if (out_tuser !== want.err) begin
          $display("%0t error_code mismatch: expected %0d, actual %0d",
                   $time, want.err, out_tuser);
          fails++;
        end
      end
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
    end
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", expected_words.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/twc_pkg.sv
design/twc_row_ram.sv
design/trie_word_count_dictionary_core.sv
tb/trie_word_count_dictionary_core_tb.sv
